// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and codes of the RESP2 stream decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_ELEM_END  = 2'd1;
  localparam logic [1:0] KIND_EMPTY_END = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // Message types
  localparam logic [1:0] MSG_STRING  = 2'd0;
  localparam logic [1:0] MSG_ERR_REP = 2'd1;
  localparam logic [1:0] MSG_INTEGER = 2'd2;
  localparam logic [1:0] MSG_ARRAY   = 2'd3;

  // Error reasons
  localparam logic [1:0] RSN_NONE     = 2'd0;
  localparam logic [1:0] RSN_BAD_TYPE = 2'd1;
  localparam logic [1:0] RSN_SHORT    = 2'd2;
  localparam logic [1:0] RSN_LIMIT    = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MAX_ELEM = 2'd0;
  localparam logic [1:0] REG_MAX_BULK = 2'd1;

  // Stream characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [16:0] ACC_SAT = 17'h1FFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] msg_type;
    logic [7:0] elem_index;
    logic [7:0] payload_byte;
    logic       is_null;
    logic       message_last;
    logic [1:0] error_reason;
  } res_t;

endpackage

// ===== rtl/core/rsd_ifs.sv =====
// ----------------------------------------------------------------------------
// rsd_ifs
// Byte input channel and result output channel of the RESP2 decoder.
// ----------------------------------------------------------------------------
interface rsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] msg_type;
  logic [7:0] elem_index;
  logic [7:0] payload_byte;
  logic       is_null;
  logic       message_last;
  logic [1:0] error_reason;

  modport source (output valid, output kind, output msg_type, output elem_index,
                  output payload_byte, output is_null, output message_last,
                  output error_reason, input ready);
  modport sink   (input valid, input kind, input msg_type, input elem_index,
                  input payload_byte, input is_null, input message_last,
                  input error_reason, output ready);
endinterface

// ===== rtl/core/resp_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// resp_stream_decoder
// RESP2 reply parser: one stream byte in, at most one result item out.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake      | payload
//  ----------+-----------+----------------+-------------------------------------
//  in_bus    | sink      | valid / ready  | data_byte
//  out_bus   | source    | valid / ready  | kind, msg_type, elem_index,
//            |           |                | payload_byte, is_null, message_last,
//            |           |                | error_reason
//  cfg_*     | write     | cfg_we         | cfg_index, cfg_data
//
//  One byte per cycle. A byte updates the parser state in the cycle it is
//  accepted; its result item (if any) sits in the output register next cycle.
//  in_bus.ready = output register empty or being drained, so the decoder
//  only stalls while a result waits on a stalled sink.
//  rst_n is synchronous: parser state and output valid clear, limits return
//  to 256 elements and 65535 bulk bytes.
// ----------------------------------------------------------------------------
module resp_stream_decoder
  import rsd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 256,
  parameter int MAX_BULK_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  rsd_in_if.sink      in_bus,
  rsd_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Parameters only clamp the register limits; registers are 9 / 16 bits.
  localparam logic [8:0]  ELEM_CAP = (MAX_ELEMENTS > 511)   ? 9'h1FF   : 9'(MAX_ELEMENTS);
  localparam logic [15:0] BULK_CAP = (MAX_BULK_LEN > 65535) ? 16'hFFFF : 16'(MAX_BULK_LEN);

  typedef enum logic [4:0] {
    PH_TYPE  = 5'b00001,
    PH_COUNT = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_LINE  = 5'b01000,
    PH_BULK  = 5'b10000
  } phase_t;

  // Configuration
  logic [8:0]  max_elem_r;
  logic [15:0] max_bulk_r;

  // Parser state
  phase_t      phase_r,      phase_nxt;
  logic [1:0]  cur_type_r,   cur_type_nxt;
  logic        in_array_r,   in_array_nxt;
  logic [8:0]  elems_left_r, elems_left_nxt;
  logic [7:0]  elem_num_r,   elem_num_nxt;
  logic [16:0] bytes_left_r, bytes_left_nxt;
  logic [16:0] acc_r,        acc_nxt;
  logic        neg_r,        neg_nxt;
  logic        stopped_r,    stopped_nxt;
  logic [7:0]  held_byte_r,  held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;

  // Output register
  logic        out_valid_r;
  res_t        res_r;

  logic        in_fire;
  logic        in_rdy;
  logic [7:0]  b;
  logic [8:0]  elem_lim;
  logic [15:0] bulk_lim;
  logic [20:0] acc_mul;
  logic [16:0] bl_dec;

  // Result of the current byte
  logic        emit_vld;
  res_t        emit;

  // Actions resolved after the phase decode
  logic        do_finish, finish_null;
  logic        do_fail;
  logic [1:0]  fail_reason;
  logic        do_start;
  logic        do_clear;
  logic        fin_last;

  assign in_rdy   = !out_valid_r || out_bus.ready;
  assign in_fire  = in_bus.valid && in_rdy;
  assign b        = in_bus.data_byte;
  assign elem_lim = (max_elem_r < ELEM_CAP) ? max_elem_r : ELEM_CAP;
  assign bulk_lim = (max_bulk_r < BULK_CAP) ? max_bulk_r : BULK_CAP;
  // acc * 10 + digit, wide enough to never wrap before saturation
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {17'd0, 4'(b - CH_ZERO)};
  assign bl_dec   = (bytes_left_r != 17'd0) ? (bytes_left_r - 17'd1) : 17'd0;
  assign fin_last = !in_array_r || (elems_left_r <= 9'd1);

  always_comb begin
    phase_nxt      = phase_r;
    cur_type_nxt   = cur_type_r;
    in_array_nxt   = in_array_r;
    elems_left_nxt = elems_left_r;
    elem_num_nxt   = elem_num_r;
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    stopped_nxt    = stopped_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;

    emit_vld          = 1'b0;
    emit.kind         = KIND_PAYLOAD;
    emit.msg_type     = cur_type_r;
    emit.elem_index   = elem_num_r;
    emit.payload_byte = 8'd0;
    emit.is_null      = 1'b0;
    emit.message_last = 1'b0;
    emit.error_reason = RSN_NONE;

    do_finish   = 1'b0;
    finish_null = 1'b0;
    do_fail     = 1'b0;
    fail_reason = RSN_NONE;
    do_start    = 1'b0;
    do_clear    = 1'b0;

    if (in_fire) begin
      case (phase_r)
        PH_COUNT, PH_LEN: begin
          if (b == CH_LF) begin
            if (phase_r == PH_COUNT) begin
              if (neg_r || acc_r == 17'd0) begin
                // empty or null array
                emit_vld          = 1'b1;
                emit.kind         = KIND_EMPTY_END;
                emit.message_last = 1'b1;
                do_clear          = 1'b1;
              end else if (acc_r > {8'd0, elem_lim}) begin
                do_fail     = 1'b1;
                fail_reason = RSN_LIMIT;
              end else begin
                in_array_nxt   = 1'b1;
                elems_left_nxt = acc_r[8:0];
                elem_num_nxt   = 8'd0;
                phase_nxt      = PH_TYPE;
                do_start       = 1'b1;
              end
            end else begin
              if (neg_r && acc_r != 17'd0) begin
                if (acc_r == 17'd1) begin
                  // null bulk string
                  do_finish   = 1'b1;
                  finish_null = 1'b1;
                end else begin
                  do_fail     = 1'b1;
                  fail_reason = RSN_LIMIT;
                end
              end else if (acc_r > {1'b0, bulk_lim}) begin
                do_fail     = 1'b1;
                fail_reason = RSN_LIMIT;
              end else begin
                bytes_left_nxt = acc_r + 17'd2;
                phase_nxt      = PH_BULK;
                do_start       = 1'b1;
              end
            end
          end else if (!stopped_r) begin
            // decimal digit feed; sign allowed on the first byte only
            if (!held_valid_r && b == CH_MINUS) begin
              held_valid_nxt = 1'b1;
              neg_nxt        = 1'b1;
            end else if (!held_valid_r && b == CH_PLUS) begin
              held_valid_nxt = 1'b1;
            end else begin
              held_valid_nxt = 1'b1;
              if (b >= CH_ZERO && b <= CH_NINE) begin
                acc_nxt = (acc_mul > {4'd0, ACC_SAT}) ? ACC_SAT : acc_mul[16:0];
              end else begin
                stopped_nxt = 1'b1;
              end
            end
          end
        end
        PH_LINE: begin
          if (b == CH_LF) begin
            if (!held_valid_r) begin
              do_fail     = 1'b1;
              fail_reason = RSN_SHORT;
            end else begin
              do_finish = 1'b1;
            end
          end else begin
            // one-byte delay drops the byte before LF
            if (held_valid_r) begin
              emit_vld          = 1'b1;
              emit.payload_byte = held_byte_r;
            end
            held_byte_nxt  = b;
            held_valid_nxt = 1'b1;
          end
        end
        PH_BULK: begin
          if (bytes_left_r > 17'd2) begin
            emit_vld          = 1'b1;
            emit.payload_byte = b;
          end
          bytes_left_nxt = bl_dec;
          if (bl_dec == 17'd0) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          // type byte
          do_start = 1'b1;
          if (b == CH_PLUS) begin
            if (!in_array_r) cur_type_nxt = MSG_STRING;
            phase_nxt = PH_LINE;
          end else if (b == CH_MINUS) begin
            if (!in_array_r) cur_type_nxt = MSG_ERR_REP;
            phase_nxt = PH_LINE;
          end else if (b == CH_COLON) begin
            if (!in_array_r) cur_type_nxt = MSG_INTEGER;
            phase_nxt = PH_LINE;
          end else if (b == CH_DOLLAR) begin
            if (!in_array_r) cur_type_nxt = MSG_STRING;
            phase_nxt = PH_LEN;
          end else if (b == CH_STAR) begin
            if (in_array_r) begin
              // nested array
              do_fail     = 1'b1;
              fail_reason = RSN_LIMIT;
            end else begin
              cur_type_nxt = MSG_ARRAY;
              phase_nxt    = PH_COUNT;
            end
          end else begin
            do_fail     = 1'b1;
            fail_reason = RSN_BAD_TYPE;
          end
        end
      endcase
    end

    // element end; replaces any payload result of the same byte
    if (do_finish) begin
      emit_vld          = 1'b1;
      emit.kind         = KIND_ELEM_END;
      emit.payload_byte = 8'd0;
      emit.is_null      = finish_null;
      emit.message_last = fin_last;
      if (fin_last) begin
        do_clear = 1'b1;
      end else begin
        elems_left_nxt = elems_left_r - 9'd1;
        elem_num_nxt   = elem_num_r + 8'd1;
        phase_nxt      = PH_TYPE;
        do_start       = 1'b1;
      end
    end

    if (do_fail) begin
      emit_vld          = 1'b1;
      emit.kind         = KIND_ERROR;
      emit.payload_byte = 8'd0;
      emit.message_last = 1'b1;
      emit.error_reason = fail_reason;
      do_clear          = 1'b1;
    end

    if (do_start || do_clear) begin
      acc_nxt        = 17'd0;
      neg_nxt        = 1'b0;
      stopped_nxt    = 1'b0;
      held_byte_nxt  = 8'd0;
      held_valid_nxt = 1'b0;
    end

    if (do_clear) begin
      phase_nxt      = PH_TYPE;
      cur_type_nxt   = MSG_STRING;
      in_array_nxt   = 1'b0;
      elems_left_nxt = 9'd0;
      elem_num_nxt   = 8'd0;
      bytes_left_nxt = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_elem_r   <= 9'd256;
      max_bulk_r   <= 16'hFFFF;
      phase_r      <= PH_TYPE;
      cur_type_r   <= MSG_STRING;
      in_array_r   <= 1'b0;
      elems_left_r <= 9'd0;
      elem_num_r   <= 8'd0;
      bytes_left_r <= 17'd0;
      acc_r        <= 17'd0;
      neg_r        <= 1'b0;
      stopped_r    <= 1'b0;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ELEM: max_elem_r <= cfg_data[8:0];
          REG_MAX_BULK: max_bulk_r <= cfg_data;
          default: ;
        endcase
      end
      phase_r      <= phase_nxt;
      cur_type_r   <= cur_type_nxt;
      in_array_r   <= in_array_nxt;
      elems_left_r <= elems_left_nxt;
      elem_num_r   <= elem_num_nxt;
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      stopped_r    <= stopped_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      if (in_rdy) begin
        out_valid_r <= in_fire && emit_vld;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_rdy) begin
      res_r <= emit;
    end
  end

  assign in_bus.ready         = in_rdy;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.kind         = res_r.kind;
  assign out_bus.msg_type     = res_r.msg_type;
  assign out_bus.elem_index   = res_r.elem_index;
  assign out_bus.payload_byte = res_r.payload_byte;
  assign out_bus.is_null      = res_r.is_null;
  assign out_bus.message_last = res_r.message_last;
  assign out_bus.error_reason = res_r.error_reason;

endmodule

// ===== rtl/core/rsd_checker.sv =====
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks of the RESP2 decoder, bound into the decoder module.
// ----------------------------------------------------------------------------
module rsd_checker
  import rsd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_payload_byte,
  input logic       out_is_null,
  input logic       out_message_last,
  input logic [1:0] out_error_reason
);

  // output register empties on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // errors close the message and carry a reason; others carry none
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERROR) ==
                   (out_error_reason != RSN_NONE)) &&
                  ((out_kind != KIND_ERROR) || out_message_last))
    else $error("error item fields inconsistent");

  // payload byte and null flag only on their own kinds; payload items never end the message
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_PAYLOAD) || (out_payload_byte == 8'd0)) &&
                  (!out_is_null || (out_kind == KIND_ELEM_END)) &&
                  ((out_kind != KIND_PAYLOAD) || !out_message_last))
    else $error("result fields do not match kind");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_payload_byte))
    else $error("stalled result changed");

endmodule

bind resp_stream_decoder rsd_checker u_rsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_kind         (out_bus.kind),
  .out_payload_byte (out_bus.payload_byte),
  .out_is_null      (out_bus.is_null),
  .out_message_last (out_bus.message_last),
  .out_error_reason (out_bus.error_reason)
);

// ===== test/resp_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_stream_decoder_test
// Self-checking bench for the RESP2 stream decoder. Byte streams (directed
// replies, then random replies with occasional garbage) are pushed through
// the input channel. Each accepted byte runs through a local decoder model,
// and the result items it predicts are compared in order against the output
// channel. Limits are reprogrammed between phases while the decoder is idle.
// ----------------------------------------------------------------------------
module resp_stream_decoder_test;
  import rsd_pkg::*;

  // Build-time caps of the uut (defaults)
  localparam int ELEM_CAP = 256;
  localparam int BULK_CAP = 65535;

  localparam int SETTLE_CYCLES    = 4;     // result lands in the cycle after accept
  localparam int QUIET_LIMIT      = 2000;  // cycles without any handshake
  localparam int SHOWN_MISMATCHES = 10;

  localparam logic [7:0] CH_CR = 8'h0D;

  // Indexes past the register list; writes there must be dropped
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [2:0] {
    SEEK_TYPE,
    READ_COUNT,
    READ_LEN,
    READ_LINE,
    READ_BULK
  } parse_at_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  rsd_in_if  in_bus ();
  rsd_out_if out_bus ();

  resp_stream_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder model state
  // --------------------------------------------------------------------------
  logic [7:0] stream_bytes[$];   // bytes still to be sent
  res_t       decoded_items[$];  // result items predicted, oldest first
  int         bytes_added;
  int         mismatch_count;

  // Idle/stall probabilities in percent, changed only between phases
  int send_idle_pct;
  int recv_stall_pct;

  parse_at_t   parse_at;
  logic [1:0]  cur_msg_type;
  logic        in_array_msg;
  logic [8:0]  elems_remaining;
  logic [7:0]  elem_no;
  logic [16:0] bulk_remaining;   // payload plus the two trailer bytes
  logic [16:0] num_value;
  logic        num_neg;
  logic        num_done;         // non-digit seen, rest of count/length line ignored
  logic [7:0]  held_byte;        // line byte kept back until the next one
  logic        held_ok;
  logic [8:0]  elem_limit_reg;
  logic [15:0] bulk_limit_reg;

  function automatic int elem_limit();
    return (elem_limit_reg < ELEM_CAP) ? int'(elem_limit_reg) : ELEM_CAP;
  endfunction

  function automatic int bulk_limit();
    return (bulk_limit_reg < BULK_CAP) ? int'(bulk_limit_reg) : BULK_CAP;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [7:0] pay, logic nul,
                                      logic last, logic [1:0] rsn);
    res_t r;
    r.kind         = k;
    r.msg_type     = cur_msg_type;
    r.elem_index   = elem_no;
    r.payload_byte = pay;
    r.is_null      = nul;
    r.message_last = last;
    r.error_reason = rsn;
    decoded_items = {decoded_items, r};
  endfunction

  function automatic void restart_line();
    num_value = '0;
    num_neg   = 1'b0;
    num_done  = 1'b0;
    held_byte = '0;
    held_ok   = 1'b0;
  endfunction

  function automatic void drop_message();
    parse_at        = SEEK_TYPE;
    cur_msg_type    = MSG_STRING;
    in_array_msg    = 1'b0;
    elems_remaining = '0;
    elem_no         = '0;
    bulk_remaining  = '0;
    restart_line();
  endfunction

  function automatic void reset_model();
    elem_limit_reg = 9'd256;
    bulk_limit_reg = 16'd65535;
    drop_message();
  endfunction

  // Error item carries the type/index that held before it, then all clears
  function automatic void flag_error(logic [1:0] rsn);
    push_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, rsn);
    drop_message();
  endfunction

  function automatic void close_element(logic nul);
    logic last;
    last = !in_array_msg || (elems_remaining <= 9'd1);
    push_result(KIND_ELEM_END, 8'h00, nul, last, RSN_NONE);
    if (last) begin
      drop_message();
    end else begin
      elems_remaining = elems_remaining - 9'd1;
      elem_no         = elem_no + 8'd1;
      parse_at        = SEEK_TYPE;
      restart_line();
    end
  endfunction

  // Signed decimal: sign only as first byte, stop at any other non-digit
  function automatic void feed_digit(logic [7:0] b);
    int unsigned v;
    if (!num_done) begin
      if (!held_ok && (b == CH_MINUS || b == CH_PLUS)) begin
        held_ok = 1'b1;
        if (b == CH_MINUS) num_neg = 1'b1;
      end else begin
        held_ok = 1'b1;
        if (b >= CH_ZERO && b <= CH_NINE) begin
          v = 32'(num_value) * 10 + 32'(b - CH_ZERO);
          num_value = (v > 32'(ACC_SAT)) ? ACC_SAT : v[16:0];
        end else begin
          num_done = 1'b1;
        end
      end
    end
  endfunction

  function automatic void on_type_byte(logic [7:0] b);
    restart_line();
    case (b)
      CH_PLUS: begin
        if (!in_array_msg) cur_msg_type = MSG_STRING;
        parse_at = READ_LINE;
      end
      CH_MINUS: begin
        if (!in_array_msg) cur_msg_type = MSG_ERR_REP;
        parse_at = READ_LINE;
      end
      CH_COLON: begin
        if (!in_array_msg) cur_msg_type = MSG_INTEGER;
        parse_at = READ_LINE;
      end
      CH_DOLLAR: begin
        if (!in_array_msg) cur_msg_type = MSG_STRING;
        parse_at = READ_LEN;
      end
      CH_STAR: begin
        if (in_array_msg) begin
          flag_error(RSN_LIMIT);  // no nesting
        end else begin
          cur_msg_type = MSG_ARRAY;
          parse_at     = READ_COUNT;
        end
      end
      default: flag_error(RSN_BAD_TYPE);
    endcase
  endfunction

  function automatic void end_count_line();
    if (num_neg || num_value == 0) begin
      push_result(KIND_EMPTY_END, 8'h00, 1'b0, 1'b1, RSN_NONE);
      drop_message();
    end else if (num_value > elem_limit()) begin
      flag_error(RSN_LIMIT);
    end else begin
      in_array_msg    = 1'b1;
      elems_remaining = num_value[8:0];
      elem_no         = '0;
      parse_at        = SEEK_TYPE;
      restart_line();
    end
  endfunction

  function automatic void end_length_line();
    if (num_neg && num_value != 0) begin
      if (num_value == 1) close_element(1'b1);  // null bulk
      else flag_error(RSN_LIMIT);
    end else if (num_value > bulk_limit()) begin
      flag_error(RSN_LIMIT);
    end else begin
      bulk_remaining = num_value + 17'd2;
      parse_at       = READ_BULK;
      restart_line();
    end
  endfunction

  function automatic void decode_stream_byte(logic [7:0] b);
    case (parse_at)
      READ_COUNT: begin
        if (b == CH_LF) end_count_line();
        else feed_digit(b);
      end
      READ_LEN: begin
        if (b == CH_LF) end_length_line();
        else feed_digit(b);
      end
      READ_LINE: begin
        if (b == CH_LF) begin
          if (!held_ok) flag_error(RSN_SHORT);
          else close_element(1'b0);  // held byte (the CR) is dropped
        end else if (held_ok) begin
          push_result(KIND_PAYLOAD, held_byte, 1'b0, 1'b0, RSN_NONE);
          held_byte = b;
        end else begin
          held_byte = b;
          held_ok   = 1'b1;
        end
      end
      READ_BULK: begin
        if (bulk_remaining > 17'd2)
          push_result(KIND_PAYLOAD, b, 1'b0, 1'b0, RSN_NONE);
        if (bulk_remaining > 0) bulk_remaining = bulk_remaining - 17'd1;
        if (bulk_remaining == 0) close_element(1'b0);
      end
      default: on_type_byte(b);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    stream_bytes = {stream_bytes, b};
    bytes_added++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void add_simple(logic [7:0] type_ch, string body);
    add_byte(type_ch);
    add_text(body);
    add_crlf();
  endfunction

  function automatic void add_header(logic [7:0] type_ch, int n);
    add_byte(type_ch);
    add_text($sformatf("%0d", n));
    add_crlf();
  endfunction

  function automatic void add_bulk(string body);
    add_header(CH_DOLLAR, body.len());
    add_text(body);
    add_crlf();
  endfunction

  // Mostly printable; sometimes any byte except LF
  function automatic logic [7:0] rand_line_byte();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 80) begin
      b = 8'($urandom_range(8'h20, 8'h7E));
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF) b = CH_CR;
    end
    return b;
  endfunction

  function automatic void add_random_line();
    logic [7:0] type_ch;
    int pick;
    int n;
    pick = $urandom_range(0, 2);
    type_ch = (pick == 0) ? CH_PLUS : (pick == 1) ? CH_MINUS : CH_COLON;
    add_byte(type_ch);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      add_byte(CH_LF);  // short line
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) add_byte(rand_line_byte());
      if (pick < 85) add_crlf();
      else add_byte(CH_LF);  // bare LF eats the last content byte
    end
  endfunction

  function automatic void add_random_bulk();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      add_header(CH_DOLLAR, -1);
    end else if (pick < 13) begin
      add_header(CH_DOLLAR, -int'($urandom_range(2, 9)));
    end else if (pick < 18 && bulk_limit() < BULK_CAP) begin
      add_header(CH_DOLLAR, bulk_limit() + int'($urandom_range(1, 3)));
    end else begin
      n = (pick < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      add_header(CH_DOLLAR, n);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 80) add_crlf();
      else repeat (2) add_byte(8'($urandom_range(0, 255)));  // trailer unchecked
    end
  endfunction

  // Count/length line with signs, blanks and junk mixed in
  function automatic void add_odd_number_line();
    string num_chars;
    int n;
    num_chars = "0123456789+- x";
    add_byte(($urandom_range(0, 1) == 0) ? CH_DOLLAR : CH_STAR);
    n = $urandom_range(0, 3);
    repeat (n) add_byte(num_chars[$urandom_range(0, num_chars.len() - 1)]);
    add_crlf();
  endfunction

  function automatic void add_random_message();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_random_line();
    end else if (pick < 45) begin
      add_random_bulk();
    end else if (pick < 80) begin
      n = $urandom_range(0, 99);
      if (n < 8) n = -int'($urandom_range(0, 3));
      else if (n < 12) n = elem_limit() + 1;
      else n = $urandom_range(1, 5);
      add_header(CH_STAR, n);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) add_header(CH_STAR, 1);  // nested array
        else if (pick < 50) add_random_line();
        else add_random_bulk();
      end
    end else if (pick < 90) begin
      add_odd_number_line();
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void queue_random(int n);
    int target;
    target = bytes_added + n;
    while (bytes_added < target) add_random_message();
  endfunction

  function automatic void queue_directed();
    add_simple(CH_PLUS, "OK");
    add_simple(CH_MINUS, "ERR no");
    add_simple(CH_COLON, "-42");
    add_bulk("abc");
    add_header(CH_DOLLAR, -1);       // null bulk
    add_bulk("");                    // empty bulk
    add_header(CH_DOLLAR, -2);       // length below -1
    add_header(CH_DOLLAR, 65536);    // above bulk limit
    add_header(CH_STAR, 0);          // empty array
    add_header(CH_STAR, -1);         // null array
    add_header(CH_STAR, 3);          // array keeps type on simple items
    add_bulk("x");
    add_header(CH_DOLLAR, -1);
    add_simple(CH_COLON, "5");
    add_header(CH_STAR, 257);        // above count limit
    add_header(CH_STAR, 1);
    add_byte(CH_STAR);               // nested array
    add_byte(CH_PLUS);
    add_byte(CH_LF);                 // short line
    add_text("+z");
    add_byte(CH_LF);                 // bare LF: 'z' dropped
    add_byte(8'h00);                 // bad type bytes
    add_byte(8'hFF);
    add_text("?");
    add_header(CH_DOLLAR, 2);        // extreme payload bytes, odd trailer
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_LF);
    add_byte(CH_LF);
    add_text("$ 3");                 // leading blank: reads as zero
    add_crlf();
    add_crlf();
    add_text("$+3x9");               // plus sign, stops at 'x'
    add_crlf();
    add_text("abc");
    add_crlf();
    add_text("$--1");                // second sign stops parsing: zero
    add_crlf();
    add_crlf();
    add_byte(CH_STAR);               // empty count line
    add_byte(CH_LF);
    add_header(CH_STAR, 999999);     // saturated count
    add_header(CH_DOLLAR, 999999);   // saturated length
    add_header(CH_DOLLAR, 2);        // LF inside bulk content
    add_byte(CH_LF);
    add_byte(CH_LF);
    add_crlf();
  endfunction

  // --------------------------------------------------------------------------
  // Gap lengths: mostly short, a few long
  // --------------------------------------------------------------------------
  function automatic int draw_gap(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver: every accepted byte goes through the model right away
  // --------------------------------------------------------------------------
  int send_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid     <= 1'b0;
      in_bus.data_byte <= '0;
      send_wait        <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) decode_stream_byte(in_bus.data_byte);
      if (in_bus.valid && !in_bus.ready) begin
        // hold the byte until taken
      end else if (send_wait != 0) begin
        in_bus.valid <= 1'b0;
        send_wait    <= send_wait - 1;
      end else if (stream_bytes.size() != 0) begin
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= stream_bytes.pop_front();
        send_wait        <= draw_gap(send_idle_pct);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  int stall_left;

  function automatic void flag_mismatch(string what, res_t want, res_t got);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES) begin
      $display("%0t %s: want kind=%0d type=%0d idx=%0d byte=%h null=%b last=%b rsn=%0d",
               $time, what, want.kind, want.msg_type, want.elem_index,
               want.payload_byte, want.is_null, want.message_last, want.error_reason);
      $display("    got  kind=%0d type=%0d idx=%0d byte=%h null=%b last=%b rsn=%0d",
               got.kind, got.msg_type, got.elem_index, got.payload_byte,
               got.is_null, got.message_last, got.error_reason);
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    res_t seen;
    res_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen.kind         = out_bus.kind;
        seen.msg_type     = out_bus.msg_type;
        seen.elem_index   = out_bus.elem_index;
        seen.payload_byte = out_bus.payload_byte;
        seen.is_null      = out_bus.is_null;
        seen.message_last = out_bus.message_last;
        seen.error_reason = out_bus.error_reason;
        if (decoded_items.size() == 0) begin
          flag_mismatch("unexpected item", '0, seen);
        end else begin
          want = decoded_items.pop_front();
          if (seen !== want) flag_mismatch("item mismatch", want, seen);
        end
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left    <= draw_gap(recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake on either channel
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** resp_stream_decoder: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Phase control
  // --------------------------------------------------------------------------
  // Sampled mid-cycle so the queues are settled after the posedge updates
  task automatic wait_drained();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || in_bus.valid || decoded_items.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_ELEM: elem_limit_reg = value[8:0];
      REG_MAX_BULK: bulk_limit_reg = value;
      default: ;
    endcase
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_MAX_ELEM;
    cfg_data       = '0;
    bytes_added    = 0;
    mismatch_count = 0;
    send_idle_pct  = 40;
    recv_stall_pct = 30;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed replies at reset limits
    queue_directed();
    wait_drained();

    // Top of both ranges; spare indexes must not disturb anything.
    // Element register above the cap still limits at 256.
    write_reg(REG_MAX_ELEM, 16'h01FF);
    write_reg(REG_MAX_BULK, 16'hFFFF);
    write_reg(REG_SPARE_2, 16'h0001);
    write_reg(REG_SPARE_3, 16'h0000);
    add_header(CH_STAR, 256);  // full array, index runs to 255
    repeat (256) add_simple(CH_COLON, "");
    queue_random(60);
    wait_drained();

    // Zero limits: any non-empty array or non-empty bulk is over
    write_reg(REG_MAX_ELEM, 16'h0000);
    write_reg(REG_MAX_BULK, 16'h0000);
    add_header(CH_STAR, 1);
    add_simple(CH_PLUS, "a");
    add_bulk("");
    add_header(CH_DOLLAR, 1);
    add_header(CH_STAR, 0);
    queue_random(50);
    wait_drained();

    // Small limits, exact boundaries
    write_reg(REG_MAX_ELEM, 16'd3);
    write_reg(REG_MAX_BULK, 16'd5);
    add_header(CH_STAR, 3);
    add_bulk("hello");
    add_simple(CH_MINUS, "e");
    add_header(CH_DOLLAR, -1);
    add_header(CH_STAR, 4);
    add_header(CH_DOLLAR, 6);
    queue_random(70);
    wait_drained();

    // Unused upper data bits are dropped (64 elements); no idling at all
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_MAX_ELEM, 16'hFE40);
    write_reg(REG_MAX_BULK, 16'd300);
    queue_random(80);
    wait_drained();

    if (mismatch_count == 0 && decoded_items.size() == 0)
      $display("** resp_stream_decoder: PASSED **");
    else
      $display("** resp_stream_decoder: FAILED **");
    $finish;
  end

endmodule
